FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg
// Types and constants of the fault code LED blinker.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int FAULT_COUNT = 8;
  localparam int FLAGS_W     = 8;
  // only flag bits below both the fault count and the flag width are looked at
  localparam int FAULT_USED  = (FAULT_COUNT < FLAGS_W) ? FAULT_COUNT : FLAGS_W;

  localparam int TIME_W      = 32;
  localparam int CODE_W      = 4;
  localparam int STEP_W      = CODE_W + 1;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_MS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_MS = 1'b1;

  localparam logic [CFG_W-1:0] BLINK_MS_RESET = 16'd250;
  localparam logic [CFG_W-1:0] PAUSE_MS_RESET = 16'd1500;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic [FLAGS_W-1:0] fault_flags;
  } item_t;

  typedef struct packed {
    logic              led_on;
    logic [CODE_W-1:0] blink_code;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] blink_ms;
    logic [CFG_W-1:0] pause_ms;
  } cfg_t;

endpackage

FILE: rtl/core/fcb_stream_if.sv
// ----------------------------------------------------------------------------
// fcb_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fcb_stream_if #(
  parameter type payload_t = fcb_pkg::item_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/fcb_cfg_regs.sv
// ----------------------------------------------------------------------------
// fcb_cfg_regs
// Blink and pause time registers behind the plain write port.
// ----------------------------------------------------------------------------
module fcb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcb_pkg::CFG_W-1:0]       cfg_data,
  output fcb_pkg::cfg_t                   cfg
);
  import fcb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_ms <= BLINK_MS_RESET;
      cfg.pause_ms <= PAUSE_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK_MS: cfg.blink_ms <= cfg_data;
        REG_PAUSE_MS: cfg.pause_ms <= cfg_data;
        default:      ;
      endcase
    end
  end

endmodule

FILE: rtl/core/fcb_in_reg.sv
// ----------------------------------------------------------------------------
// fcb_in_reg
// Input register stage: holds one accepted transaction for the sequencer.
// ----------------------------------------------------------------------------
module fcb_in_reg (
  input  logic           clk,
  input  logic           rst,
  fcb_stream_if.sink     item,
  output logic           st_valid,
  output fcb_pkg::item_t st_item,
  input  logic           st_take
);
  import fcb_pkg::*;

  // refill when empty or when the held item moves on this cycle;
  // nothing is taken while reset is high
  assign item.ready = !rst && (!st_valid || st_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (item.ready) begin
      st_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      st_item <= item.payload;
    end
  end

endmodule

FILE: rtl/core/fcb_seq.sv
// ----------------------------------------------------------------------------
// fcb_seq
// Blink sequencer: fault encoder, step timer, state and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcb_seq (
  input  logic           clk,
  input  logic           rst,
  input  fcb_pkg::cfg_t  cfg,
  input  logic           st_valid,
  input  fcb_pkg::item_t st_item,
  output logic           st_take,
  fcb_stream_if.source   result
);
  import fcb_pkg::*;

  logic [STEP_W-1:0] step_index, step_index_next;
  logic [CODE_W-1:0] latched_code, latched_code_next;
  logic [TIME_W-1:0] step_start_ms, step_start_ms_next;
  logic              led_level, led_level_next;

  logic              res_valid;
  result_t           res_payload, res_payload_next;

  logic [CODE_W-1:0] found_code;
  logic [TIME_W-1:0] elapsed;
  logic [STEP_W-1:0] last_step;
  logic              in_pause;
  logic [CFG_W-1:0]  duration;

  assign st_take = st_valid && (!res_valid || result.ready);

  // lowest set flag wins
  always_comb begin
    found_code = '0;
    for (int k = FAULT_USED - 1; k >= 0; k--) begin
      if (st_item.fault_flags[k]) begin
        found_code = CODE_W'(k + 1);
      end
    end
  end

  assign elapsed   = st_item.now_ms - step_start_ms;
  assign last_step = {latched_code, 1'b0};
  assign in_pause  = step_index >= last_step;
  assign duration  = in_pause ? cfg.pause_ms : cfg.blink_ms;

  always_comb begin
    step_index_next    = step_index;
    latched_code_next  = latched_code;
    step_start_ms_next = step_start_ms;
    led_level_next     = led_level;
    if (step_index == '0) begin
      latched_code_next = found_code;
      if (found_code == '0) begin
        led_level_next = 1'b0;
      end else begin
        step_index_next    = STEP_W'(1);
        step_start_ms_next = st_item.now_ms;
        led_level_next     = 1'b1;
      end
    end else if (elapsed >= {{(TIME_W-CFG_W){1'b0}}, duration}) begin
      step_start_ms_next = st_item.now_ms;
      if (in_pause) begin
        step_index_next = '0;
      end else begin
        step_index_next = step_index + STEP_W'(1);
        led_level_next  = step_index_next[0];
      end
    end
    res_payload_next.led_on     = led_level_next;
    res_payload_next.blink_code = (step_index_next != '0) ? latched_code_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index    <= '0;
      latched_code  <= '0;
      step_start_ms <= '0;
      led_level     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (st_take) begin
        step_index    <= step_index_next;
        latched_code  <= latched_code_next;
        step_start_ms <= step_start_ms_next;
        led_level     <= led_level_next;
        res_valid     <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_take) begin
      res_payload <= res_payload_next;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_payload;

  `ASSERT_IMPLIES(a_busy_has_code, clk, rst, step_index != '0, latched_code != '0,
                  "sequence running with no latched code")
  `ASSERT_CLK(a_step_in_range, clk, rst, step_index <= {latched_code, 1'b0},
              "step index past the pause step")
  `ASSERT_CLK(a_led_follows_step, clk, rst, led_level == step_index[0],
              "LED level out of step with step parity")
  `ASSERT_NEXT(a_state_holds, clk, rst, !st_take, $stable(step_index) && $stable(latched_code),
               "sequencer state moved without a transaction")

endmodule

FILE: rtl/core/fault_code_led_blinker.sv
// ----------------------------------------------------------------------------
// fault_code_led_blinker
// Blinks the number of the lowest active fault on an LED, then pauses.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                      transaction when
//  -------  ---  ---------------------------  ---------------------------
//  item     in   now_ms[31:0], fault_flags[7:0]  item.valid && item.ready
//  result   out  led_on, blink_code[3:0]      result.valid && result.ready
//  cfg      in   cfg_index, cfg_data[15:0]    cfg_we (no handshake)
//
//  One result per item, one transaction per cycle sustained while result.ready
//  stays high. An item passes the input register, then sequencer logic into
//  the result register; a stalled result can hold it in the input register.
//  The sequencer step is combinational: encoder, 32-bit elapsed-time subtract
//  and compare, all between the two registers.
//  A stalled result holds; the input register still refills while the result
//  waits, then item.ready drops until the result is taken.
//  Synchronous reset: idle, LED dark, blink 250 ms, pause 1500 ms; no clearing
//  pass, item.ready low during reset, items are taken in the first cycle after.
//
module fault_code_led_blinker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcb_pkg::CFG_W-1:0]       cfg_data,
  fcb_stream_if.sink                      item,
  fcb_stream_if.source                    result
);
  import fcb_pkg::*;

  cfg_t  cfg;     // live register values, applied at once to the step running
  logic  st_valid;
  item_t st_item;
  logic  st_take; // sequencer consumes the held item this cycle

  fcb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register: parts the upstream handshake from the sequencer
  fcb_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .st_valid (st_valid),
    .st_item  (st_item),
    .st_take  (st_take)
  );

  // sequencer: state update and result register in one pass
  fcb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .st_valid (st_valid),
    .st_item  (st_item),
    .st_take  (st_take),
    .result   (result)
  );

endmodule
